>>> design/sahdma_pkg.sv
`default_nettype none
package sahdma_pkg;

  // Function codes carried in the func field of an input word
  localparam logic [2:0] FUNC_TICK   = 3'd0;
  localparam logic [2:0] FUNC_SPRITE = 3'd1;
  localparam logic [2:0] FUNC_BWRITE = 3'd2;
  localparam logic [2:0] FUNC_BREAD  = 3'd3;
  localparam logic [2:0] FUNC_HBLANK = 3'd4;

  // Result kinds
  localparam logic [1:0] KIND_IDLE = 2'd0;
  localparam logic [1:0] KIND_READ = 2'd1;
  localparam logic [1:0] KIND_COPY = 2'd2;

  // Block register offset of the length/mode register (0..3 are address bytes)
  localparam logic [2:0] OFF_LEN = 3'd4;

  // Configuration register indexes
  localparam logic CFG_DMG_MODE = 1'b0;

  localparam logic [15:0] OAM_BASE    = 16'hFE00;
  localparam logic [15:0] VRAM_BASE   = 16'h8000;
  localparam logic [15:0] BLOCK_CHUNK = 16'h0010;
  localparam logic [7:0]  ECHO_PAGE   = 8'hFE;
  localparam logic [7:0]  ECHO_ADJ    = 8'h20;
  localparam logic [7:0]  READ_NONE   = 8'hFF;

  typedef struct packed {
    logic [2:0] func;
    logic [2:0] offset;
    logic [7:0] wdata;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  read_data;
    logic [15:0] src_addr;
    logic [15:0] dst_addr;
    logic [11:0] count;
    logic        block_path;
    logic        sprite_active;
  } out_word_t;

endpackage
`default_nettype wire

>>> design/sahdma_chan_if.sv
`default_nettype none
interface sahdma_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

>>> design/sprite_and_hblank_dma_controller_top.sv
`default_nettype none
// Channel   Direction  Handshake    Word
// in_i      sink       valid/ready  sahdma_pkg::in_word_t  (func, offset, wdata)
// out_o     source     valid/ready  sahdma_pkg::out_word_t (one result per input)
// APB       slave      psel/penable dmg_mode at byte address 0
//
// Each word passes through the input register and then the result register.
// A new word is accepted every cycle while the output is not stalled.
// The input register doubles as a skid stage, so one word is still taken
// while a result waits on a stalled output. Reset clears all DMA state.
module sprite_and_hblank_dma_controller_top #(
  parameter int SPRITE_BYTES = 160
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  sahdma_chan_if.sink              in_i,
  sahdma_chan_if.source            out_o,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [2:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic      [31:0]         prdata,
  output logic                     pready
);

  localparam int LW = $clog2(SPRITE_BYTES + 1);
  localparam logic [LW-1:0] SPRITE_LEN = LW'(SPRITE_BYTES);

  // Configuration register
  logic dmg_q;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == sahdma_pkg::CFG_DMG_MODE) ? {31'd0, dmg_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dmg_q <= 1'b0;
    end else if (psel && penable && pwrite && (paddr[2] == sahdma_pkg::CFG_DMG_MODE)) begin
      dmg_q <= pwdata[0];
    end
  end

  // Input register / skid stage
  logic                  inq_valid_q;
  sahdma_pkg::in_word_t  inq_q;
  logic                  out_valid_q;
  sahdma_pkg::out_word_t out_q;
  logic                  advance;
  logic                  in_acc;

  assign advance  = !out_valid_q || out_o.ready;
  assign in_i.ready = !inq_valid_q || advance;
  assign in_acc   = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inq_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      inq_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      inq_q <= in_i.payload;
    end
  end

  // DMA state
  logic          sp_valid_q, sp_valid_d;
  logic          sp_wait_q, sp_wait_d;
  logic          sp_busy_q, sp_busy_d;
  logic          sp_old_q, sp_old_d;
  logic [15:0]   sp_src_q, sp_src_d;
  logic [LW-1:0] sp_left_q, sp_left_d;
  logic [7:0]    blk_regs_q [4];
  logic [7:0]    blk_regs_d [4];
  logic          blk_req_q, blk_req_d;
  logic [15:0]   blk_src_q, blk_src_d;
  logic [15:0]   blk_dst_q, blk_dst_d;
  logic [11:0]   blk_left_q, blk_left_d;
  sahdma_pkg::out_word_t res;

  logic          step;
  logic [15:0]   sp_start_src;
  logic [15:0]   blk_s, blk_d;
  logic [11:0]   blk_n;
  logic [7:0]    len_rd;
  logic [LW-1:0] sp_done;

  assign step = inq_valid_q && advance;

  // Start address of a sprite copy; echo pages map back by 0x2000
  assign sp_start_src = (inq_q.wdata >= sahdma_pkg::ECHO_PAGE)
                      ? {inq_q.wdata - sahdma_pkg::ECHO_ADJ, 8'h00}
                      : {inq_q.wdata, 8'h00};

  // Block addresses from the four address bytes
  assign blk_s = {blk_regs_q[0], blk_regs_q[1][7:4], 4'h0};
  assign blk_d = sahdma_pkg::VRAM_BASE + {3'b000, blk_regs_q[2][4:0], blk_regs_q[3][7:4], 4'h0};
  assign blk_n = {8'(inq_q.wdata[6:0]) + 8'd1, 4'h0};
  assign len_rd = blk_left_q[11:4] + 8'd1;
  assign sp_done = SPRITE_LEN - sp_left_q;

  always_comb begin
    sp_valid_d = sp_valid_q;
    sp_wait_d  = sp_wait_q;
    sp_busy_d  = sp_busy_q;
    sp_old_d   = sp_old_q;
    sp_src_d   = sp_src_q;
    sp_left_d  = sp_left_q;
    blk_regs_d = blk_regs_q;
    blk_req_d  = blk_req_q;
    blk_src_d  = blk_src_q;
    blk_dst_d  = blk_dst_q;
    blk_left_d = blk_left_q;
    res        = '0;

    case (inq_q.func)
      sahdma_pkg::FUNC_TICK: begin
        if (sp_valid_q) begin
          sp_old_d = 1'b0;
          if (sp_left_q == '0) begin
            sp_valid_d = 1'b0;
            sp_busy_d  = 1'b0;
          end else if (sp_wait_q) begin
            sp_wait_d = 1'b0;
          end else begin
            sp_busy_d      = 1'b1;
            res.kind       = sahdma_pkg::KIND_COPY;
            res.src_addr   = sp_src_q;
            res.dst_addr   = sahdma_pkg::OAM_BASE + 16'(sp_done);
            res.count      = 12'd1;
            res.block_path = 1'b0;
            sp_src_d       = sp_src_q + 16'd1;
            sp_left_d      = sp_left_q - LW'(1);
          end
        end
      end
      sahdma_pkg::FUNC_SPRITE: begin
        // Restart cancels a running copy; sprite_active stays set until the next tick
        if (sp_valid_q && sp_busy_q) sp_old_d = 1'b1;
        sp_src_d   = sp_start_src;
        sp_left_d  = SPRITE_LEN;
        sp_valid_d = 1'b1;
        sp_wait_d  = 1'b1;
        sp_busy_d  = 1'b0;
      end
      sahdma_pkg::FUNC_BWRITE: begin
        if (!dmg_q) begin
          if (!inq_q.offset[2]) begin
            blk_regs_d[inq_q.offset[1:0]] = inq_q.wdata;
          end else if (inq_q.offset == sahdma_pkg::OFF_LEN) begin
            blk_req_d = 1'b1;
            if (inq_q.wdata[7]) begin
              blk_src_d  = blk_s;
              blk_dst_d  = blk_d;
              blk_left_d = blk_n;
            end else begin
              res.kind       = sahdma_pkg::KIND_COPY;
              res.src_addr   = blk_s;
              res.dst_addr   = blk_d;
              res.count      = blk_n;
              res.block_path = 1'b1;
              blk_src_d      = blk_s + 16'(blk_n);
              blk_dst_d      = blk_d + 16'(blk_n);
              blk_left_d     = '0;
            end
          end
        end
      end
      sahdma_pkg::FUNC_BREAD: begin
        res.kind      = sahdma_pkg::KIND_READ;
        res.read_data = sahdma_pkg::READ_NONE;
        if (!dmg_q) begin
          if (!inq_q.offset[2]) begin
            res.read_data = blk_regs_q[inq_q.offset[1:0]];
          end else if (inq_q.offset == sahdma_pkg::OFF_LEN) begin
            if (blk_req_q && (blk_left_q != '0)) res.read_data = len_rd;
          end
        end
      end
      sahdma_pkg::FUNC_HBLANK: begin
        if (blk_req_q && (blk_left_q != '0)) begin
          res.kind       = sahdma_pkg::KIND_COPY;
          res.src_addr   = blk_src_q;
          res.dst_addr   = blk_dst_q;
          res.count      = 12'(sahdma_pkg::BLOCK_CHUNK);
          res.block_path = 1'b1;
          blk_src_d      = blk_src_q + sahdma_pkg::BLOCK_CHUNK;
          blk_dst_d      = blk_dst_q + sahdma_pkg::BLOCK_CHUNK;
          blk_left_d     = (blk_left_q >= 12'(sahdma_pkg::BLOCK_CHUNK))
                         ? blk_left_q - 12'(sahdma_pkg::BLOCK_CHUNK) : '0;
        end
      end
      default: begin
      end
    endcase

    res.sprite_active = (sp_valid_d && sp_busy_d) || sp_old_d;
  end

  // State update as the word moves into the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_valid_q <= 1'b0;
      sp_wait_q  <= 1'b0;
      sp_busy_q  <= 1'b0;
      sp_old_q   <= 1'b0;
      sp_src_q   <= '0;
      sp_left_q  <= '0;
      blk_regs_q <= '{default: '0};
      blk_req_q  <= 1'b0;
      blk_src_q  <= '0;
      blk_dst_q  <= '0;
      blk_left_q <= '0;
    end else if (step) begin
      sp_valid_q <= sp_valid_d;
      sp_wait_q  <= sp_wait_d;
      sp_busy_q  <= sp_busy_d;
      sp_old_q   <= sp_old_d;
      sp_src_q   <= sp_src_d;
      sp_left_q  <= sp_left_d;
      blk_regs_q <= blk_regs_d;
      blk_req_q  <= blk_req_d;
      blk_src_q  <= blk_src_d;
      blk_dst_q  <= blk_dst_d;
      blk_left_q <= blk_left_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= inq_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= res;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

endmodule
`default_nettype wire
